[design/pel_pkg.sv]
// Package for the peak envelope limiter: payload structs, configuration
// types, register indexes, smoother coefficients and sizing constants.
// No dependencies.
package pel_pkg;

  // Sample and level formats
  localparam int SAMPLE_BITS    = 16;
  localparam int LEVEL_BITS_DEF = 24;

  // Configuration registers
  localparam int THR_BITS   = 15;
  localparam int REL_BITS   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 1'd1;

  localparam logic [THR_BITS-1:0] THRESHOLD_RST = 15'd1638;
  localparam logic [REL_BITS-1:0] RELEASE_RST   = 16'd380;

  // One-pole smoother coefficients, Q0.16
  localparam int COEF_W = 16;
  localparam logic [COEF_W-1:0] COEF_NEW = 16'd184;
  localparam logic [COEF_W-1:0] COEF_OLD = 16'd65349;

  // Depth of the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } in_frame_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          saturated;
  } out_result_t;

  // Classified frame: sign and magnitude of the channel sum
  typedef struct packed {
    logic                 neg;
    logic [SAMPLE_BITS:0] mag;
  } frame_t;

  typedef struct packed {
    logic [THR_BITS-1:0] threshold;
    logic [REL_BITS-1:0] release_step;
  } cfg_t;

endpackage

[design/peak_envelope_limiter_top.sv]
// Peak envelope limiter, top level. Depends on pel_pkg, pel_front, pel_queue, pel_back.
// Each frame passes through the queue and then the back end, paced by the one-bit-per-cycle
// restoring divider in the back end; the back end takes no new frame until it has
// handed the current result to the output register.
// Reset (rst_ni low, asynchronous): peak and smoothed levels clear to zero,
// threshold returns to 1638 and release_step to 380, queue and output empty.
module peak_envelope_limiter_top #(
  parameter int LEVEL_BITS = pel_pkg::LEVEL_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [pel_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pel_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Input frames
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pel_pkg::in_frame_t                in_data_i,
  // Limited samples
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pel_pkg::out_result_t              out_data_o
);
  import pel_pkg::*;

  logic [THR_BITS-1:0] threshold_q;
  logic [REL_BITS-1:0] release_q;
  cfg_t                cfg;

  frame_t front_class;
  frame_t queue_data;
  logic   queue_valid;
  logic   back_ready;

  // Configuration registers: write only, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      release_q   <= RELEASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: threshold_q <= cfg_wdata_i[THR_BITS-1:0];
        REG_RELEASE:   release_q   <= cfg_wdata_i[REL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.threshold    = threshold_q;
  assign cfg.release_step = release_q;

  // Front: sum and rectify each accepted frame
  pel_front u_front (
    .frame_i (in_data_i),
    .class_o (front_class)
  );

  // Queue: decouple frame intake from the divider-bound back end
  pel_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_class),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (queue_data)
  );

  // Back: peak hold, smoothing, division, saturation and release
  pel_back #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (queue_valid),
    .item_ready_o (back_ready),
    .item_i       (queue_data),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (out_data_o)
  );

endmodule

[design/pel_front.sv]
// Front end of the limiter: sums the stereo pair and rectifies the sum.
// Depends on pel_pkg.
module pel_front (
  input  pel_pkg::in_frame_t frame_i,
  output pel_pkg::frame_t    class_o
);
  import pel_pkg::*;

  logic signed [SAMPLE_BITS:0] sum;

  assign sum = {frame_i.left_sample[SAMPLE_BITS-1], frame_i.left_sample}
             + {frame_i.right_sample[SAMPLE_BITS-1], frame_i.right_sample};

  assign class_o.neg = sum[SAMPLE_BITS];
  assign class_o.mag = sum[SAMPLE_BITS] ? (~sum + 1'b1) : sum;

endmodule

[design/pel_queue.sv]
// Short queue of classified frames between the front and back ends.
// Depends on pel_pkg.
module pel_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  pel_pkg::frame_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output pel_pkg::frame_t pop_data_o
);
  import pel_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  frame_t             entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]     count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];

  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/pel_back.sv]
// Back end of the limiter: peak hold, smoother, iterative divider,
// saturation, peak release and the output register. Depends on pel_pkg.
module pel_back #(
  parameter int LEVEL_BITS = pel_pkg::LEVEL_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pel_pkg::cfg_t       cfg_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  pel_pkg::frame_t     item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output pel_pkg::out_result_t res_o
);
  import pel_pkg::*;

  localparam int NUM_BITS  = SAMPLE_BITS + LEVEL_BITS - 3;
  localparam int CNT_W     = $clog2(NUM_BITS);
  localparam int LVL_DIFF  = LEVEL_BITS - SAMPLE_BITS - 1;
  localparam int LVL_SHL   = (LVL_DIFF >= 0) ? LVL_DIFF : 0;
  localparam int LVL_SHR   = (LVL_DIFF < 0) ? -LVL_DIFF : 0;
  localparam int WIDE_W    = SAMPLE_BITS + 1 + LEVEL_BITS;
  localparam int THR_SHIFT = LEVEL_BITS - 2 - THR_BITS;
  localparam int THR_PAD   = LEVEL_BITS - THR_BITS - THR_SHIFT;
  localparam int PROD_W    = LEVEL_BITS + COEF_W;
  localparam int ACC_W     = PROD_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PEAK   = 3'd1;
  localparam logic [2:0] S_SMOOTH = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [LEVEL_BITS-1:0] peak_q, peak_d;
  logic [LEVEL_BITS-1:0] smooth_q, smooth_d;
  logic                  upd_q, upd_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  res_valid_q, res_valid_d;

  // Payload registers
  frame_t                item_q;
  logic [PROD_W-1:0]     prod_new_q, prod_old_q;
  logic [LEVEL_BITS-1:0] div_q;
  logic [LEVEL_BITS-1:0] rem_q, rem_d;
  logic [NUM_BITS-1:0]   num_q, num_d;
  out_result_t           res_q, res_d;

  logic [WIDE_W-1:0]     lvl_wide;
  logic [LEVEL_BITS-1:0] lvl;
  logic [THR_BITS-1:0]   thr_eff;
  logic [LEVEL_BITS-1:0] thr_lvl;
  logic [ACC_W-1:0]      acc;
  logic [LEVEL_BITS:0]   trial, trial_sub;
  logic                  trial_ge;
  logic [NUM_BITS-1:0]   lim_pos, lim_neg, q_clip;
  logic                  sat;
  logic [LEVEL_BITS-1:0] rel_lvl;
  logic                  out_free;

  // Rectified sum in level format
  assign lvl_wide = (WIDE_W'(item_q.mag) << LVL_SHL) >> LVL_SHR;
  assign lvl      = lvl_wide[LEVEL_BITS-1:0];

  assign thr_eff = (cfg_i.threshold == '0) ? THR_BITS'(1) : cfg_i.threshold;
  assign thr_lvl = {{THR_PAD{1'b0}}, thr_eff, {THR_SHIFT{1'b0}}};

  assign acc = ACC_W'(prod_new_q) + ACC_W'(prod_old_q) + ACC_W'(32768);

  // One restoring division step
  assign trial     = {rem_q, num_q[NUM_BITS-1]};
  assign trial_ge  = (trial >= {1'b0, div_q});
  assign trial_sub = trial - {1'b0, div_q};

  assign lim_pos = {{(NUM_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  assign lim_neg = {{(NUM_BITS-SAMPLE_BITS){1'b0}}, 1'b1, {(SAMPLE_BITS-1){1'b0}}};

  always_comb begin
    if (item_q.neg) begin
      sat    = (num_q > lim_neg);
      q_clip = sat ? lim_neg : num_q;
    end else begin
      sat    = (num_q > lim_pos);
      q_clip = sat ? lim_pos : num_q;
    end
  end

  assign rel_lvl  = {{(LEVEL_BITS-REL_BITS){1'b0}}, cfg_i.release_step};
  assign out_free = !res_valid_q || res_ready_i;

  assign item_ready_o = (state_q == S_IDLE);
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  always_comb begin
    state_d     = state_q;
    peak_d      = peak_q;
    smooth_d    = smooth_q;
    upd_d       = upd_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    num_d       = num_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          state_d = S_PEAK;
        end
      end
      S_PEAK: begin
        // Capture a new peak and start the smoother step
        upd_d = (lvl > peak_q);
        if (lvl > peak_q) begin
          peak_d = lvl;
        end
        state_d = S_SMOOTH;
      end
      S_SMOOTH: begin
        if (upd_q) begin
          smooth_d = acc[COEF_W +: LEVEL_BITS];
        end
        state_d = S_LOAD;
      end
      S_LOAD: begin
        rem_d   = '0;
        num_d   = {item_q.mag, {(LEVEL_BITS-4){1'b0}}};
        cnt_d   = CNT_W'(NUM_BITS - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = trial_ge ? trial_sub[LEVEL_BITS-1:0] : trial[LEVEL_BITS-1:0];
        num_d = {num_q[NUM_BITS-2:0], trial_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_valid_d      = 1'b1;
          res_d.saturated  = sat;
          res_d.out_sample = item_q.neg ? (~q_clip[SAMPLE_BITS-1:0] + 1'b1)
                                        : q_clip[SAMPLE_BITS-1:0];
          // Release the held peak, floored at zero
          peak_d  = (peak_q > rel_lvl) ? (peak_q - rel_lvl) : '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      peak_q      <= '0;
      smooth_q    <= '0;
      upd_q       <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      peak_q      <= peak_d;
      smooth_q    <= smooth_d;
      upd_q       <= upd_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && item_valid_i) begin
      item_q <= item_i;
    end
    if (state_q == S_PEAK) begin
      prod_new_q <= PROD_W'(COEF_NEW) * PROD_W'((lvl > peak_q) ? lvl : peak_q);
      prod_old_q <= PROD_W'(COEF_OLD) * PROD_W'(smooth_q);
    end
    if (state_q == S_SMOOTH) begin
      div_q <= '0;
    end
    if (state_q == S_LOAD) begin
      div_q <= (smooth_q > thr_lvl) ? smooth_q : thr_lvl;
    end
    rem_q <= rem_d;
    num_q <= num_d;
    res_q <= res_d;
  end

endmodule
